// ----- rtl/tilp_pkg.sv -----
package tilp_pkg;

  // Indicator modes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_HAZARD = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_BLINK      = 2'd2,
    REG_SCHEDULER  = 2'd3
  } reg_index_t;

  localparam int CFG_WIDTH = 16;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] BLINK_RESET      = 16'd300;
  localparam logic [CFG_WIDTH-1:0] SCHEDULER_RESET  = 16'd100;

  // Toggle between off and the requested mode
  function automatic mode_t toggle_mode(input mode_t cur, input mode_t target);
    mode_t res;
    res = (cur == target) ? MODE_OFF : target;
    return res;
  endfunction

endpackage

// ----- rtl/tilp_if.sv -----
interface tilp_in_if;
  logic valid;
  logic ready;
  logic left_level;
  logic right_level;

  modport source (output valid, output left_level, output right_level, input ready);
  modport sink (input valid, input left_level, input right_level, output ready);
endinterface

interface tilp_out_if import tilp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  left_lamp;
  logic  right_lamp;
  mode_t mode;
  logic  mode_changed;

  modport source (output valid, output left_lamp, output right_lamp, output mode,
                  output mode_changed, input ready);
  modport sink (input valid, input left_lamp, input right_lamp, input mode,
                input mode_changed, output ready);
endinterface

// ----- rtl/turn_indicator_long_press_controller_core.sv -----
// Pipeline: a tick is captured in the input register at its transfer edge and then moves into
// the result register, from which the result transfers.
// Throughput: one tick per cycle; all edge, long-press and blink logic settles between
// the input register and the result register. A stalled result holds both stages.
// Reset (rst, synchronous): clears both pipeline stages, the tick clock and all button and
// mode state, and loads the default debounce, long-press, blink and scheduler intervals.
module turn_indicator_long_press_controller_core import tilp_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  tilp_in_if.sink            tick,
  tilp_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration
  logic [CFG_WIDTH-1:0] debounce_ticks;
  logic [CFG_WIDTH-1:0] long_press_ticks;
  logic [CFG_WIDTH-1:0] blink_ticks;
  logic [CFG_WIDTH-1:0] scheduler_ticks;
  reg_index_t           cfg_sel;

  // Input stage
  logic s1_valid;
  logic s1_left;
  logic s1_right;
  logic advance;

  // Block state
  logic [TIME_BITS-1:0] now_ticks;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [TIME_BITS-1:0] start_left;
  logic [TIME_BITS-1:0] start_right;
  logic [TIME_BITS-1:0] last_blink_time;
  logic [1:0]           prev_levels;
  logic [1:0]           pressed_flags;
  logic [1:0]           long_flags;
  mode_t                mode;
  logic                 blink_phase;
  logic [CFG_WIDTH-1:0] sched_phase;

  // Next values
  logic [TIME_BITS-1:0] last_edge_time_next;
  logic [TIME_BITS-1:0] start_left_next;
  logic [TIME_BITS-1:0] start_right_next;
  logic [TIME_BITS-1:0] last_blink_time_next;
  logic [1:0]           pressed_flags_next;
  logic [1:0]           long_flags_next;
  mode_t                mode_next;
  logic                 blink_phase_next;
  logic [CFG_WIDTH-1:0] sched_phase_next;
  logic                 changed;

  // Intermediate terms
  logic                 left_chg;
  logic                 right_chg;
  logic                 edge_gap_ok;
  logic                 left_acc;
  logic                 right_acc;
  logic                 held_left;
  logic                 held_right;
  logic                 fire_left;
  logic                 fire_right;
  logic                 run_eval;
  logic [CFG_WIDTH-1:0] phase_inc;

  // APB register access
  assign pready  = 1'b1;
  assign cfg_sel = reg_index_t'(paddr[3:2]);

  always_comb begin
    case (cfg_sel)
      REG_DEBOUNCE:   prdata = {16'd0, debounce_ticks};
      REG_LONG_PRESS: prdata = {16'd0, long_press_ticks};
      REG_BLINK:      prdata = {16'd0, blink_ticks};
      REG_SCHEDULER:  prdata = {16'd0, scheduler_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      blink_ticks      <= BLINK_RESET;
      scheduler_ticks  <= SCHEDULER_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        REG_DEBOUNCE:   debounce_ticks   <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_PRESS: long_press_ticks <= pwdata[CFG_WIDTH-1:0];
        REG_BLINK:      blink_ticks      <= pwdata[CFG_WIDTH-1:0];
        REG_SCHEDULER:  scheduler_ticks  <= pwdata[CFG_WIDTH-1:0];
        default:        debounce_ticks   <= debounce_ticks;
      endcase
    end
  end

  // Pipeline moves whenever the result register is free or being drained
  assign advance    = !result.valid || result.ready;
  assign tick.ready = !s1_valid || advance;

  // Hold the tick levels in the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_left  <= tick.left_level;
      s1_right <= tick.right_level;
    end
  end

  // Debounced edge detection; a right change in the same tick as a left change sees no gap
  always_comb begin
    left_chg    = s1_left != prev_levels[0];
    right_chg   = s1_right != prev_levels[1];
    edge_gap_ok = (now_ticks - last_edge_time) > TIME_BITS'(debounce_ticks);
    left_acc    = left_chg && edge_gap_ok;
    right_acc   = right_chg && !left_chg && edge_gap_ok;

    pressed_flags_next  = pressed_flags;
    long_flags_next     = long_flags;
    start_left_next     = start_left;
    start_right_next    = start_right;
    last_edge_time_next = (left_chg || right_chg) ? now_ticks : last_edge_time;

    if (left_acc) begin
      if (!s1_left) begin
        start_left_next       = now_ticks;
        pressed_flags_next[0] = 1'b1;
      end else begin
        pressed_flags_next[0] = 1'b0;
        long_flags_next[0]    = 1'b0;
      end
    end
    if (right_acc) begin
      if (!s1_right) begin
        start_right_next      = now_ticks;
        pressed_flags_next[1] = 1'b1;
      end else begin
        pressed_flags_next[1] = 1'b0;
        long_flags_next[1]    = 1'b0;
      end
    end

    // Hold time; a press that starts this tick has zero elapsed
    if (left_acc && !s1_left) begin
      held_left = long_press_ticks == '0;
    end else begin
      held_left = (now_ticks - start_left) >= TIME_BITS'(long_press_ticks);
    end
    if (right_acc && !s1_right) begin
      held_right = long_press_ticks == '0;
    end else begin
      held_right = (now_ticks - start_right) >= TIME_BITS'(long_press_ticks);
    end

    // Scheduler period
    phase_inc        = sched_phase + 1'b1;
    run_eval         = phase_inc >= scheduler_ticks;
    sched_phase_next = run_eval ? '0 : phase_inc;

    // Long-press evaluation, left then right
    mode_next = mode;
    changed   = 1'b0;
    fire_left = run_eval && pressed_flags_next[0] && !long_flags_next[0] && held_left;
    if (fire_left) begin
      long_flags_next[0] = 1'b1;
      if (long_flags_next[1]) begin
        mode_next = toggle_mode(mode_next, MODE_HAZARD);
      end else begin
        mode_next = toggle_mode(mode_next, MODE_LEFT);
      end
      long_flags_next[1] = 1'b0;
      changed            = 1'b1;
    end
    fire_right = run_eval && pressed_flags_next[1] && !long_flags_next[1] && held_right;
    if (fire_right) begin
      long_flags_next[1] = 1'b1;
      if (long_flags_next[0]) begin
        mode_next = toggle_mode(mode_next, MODE_HAZARD);
      end else begin
        mode_next = toggle_mode(mode_next, MODE_RIGHT);
      end
      long_flags_next[0] = 1'b0;
      changed            = 1'b1;
    end

    // Blink phase, on scheduler evaluation ticks: flip on interval while active, drop to zero when off
    blink_phase_next     = blink_phase;
    last_blink_time_next = last_blink_time;
    if (run_eval) begin
      if (mode_next != MODE_OFF) begin
        if ((now_ticks - last_blink_time) >= TIME_BITS'(blink_ticks)) begin
          blink_phase_next     = !blink_phase;
          last_blink_time_next = now_ticks;
        end
      end else begin
        blink_phase_next = 1'b0;
      end
    end
  end

  // Advance block state on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks       <= '0;
      last_edge_time  <= '0;
      start_left      <= '0;
      start_right     <= '0;
      last_blink_time <= '0;
      prev_levels     <= 2'b11;
      pressed_flags   <= 2'b00;
      long_flags      <= 2'b00;
      mode            <= MODE_OFF;
      blink_phase     <= 1'b0;
      sched_phase     <= '0;
    end else if (advance && s1_valid) begin
      now_ticks       <= now_ticks + 1'b1;
      last_edge_time  <= last_edge_time_next;
      start_left      <= start_left_next;
      start_right     <= start_right_next;
      last_blink_time <= last_blink_time_next;
      prev_levels     <= {s1_right, s1_left};
      pressed_flags   <= pressed_flags_next;
      long_flags      <= long_flags_next;
      mode            <= mode_next;
      blink_phase     <= blink_phase_next;
      sched_phase     <= sched_phase_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.left_lamp    <= blink_phase_next &&
                             (mode_next == MODE_LEFT || mode_next == MODE_HAZARD);
      result.right_lamp   <= blink_phase_next &&
                             (mode_next == MODE_RIGHT || mode_next == MODE_HAZARD);
      result.mode         <= mode_next;
      result.mode_changed <= changed;
    end
  end

endmodule
